/* rtl/core/tmb_pkg.sv */
// Shared types and constants of the timer bank.
package tmb_pkg;

    localparam int NUM_TIMERS = 16;
    localparam int TIME_W     = 32;
    localparam int DL_W       = TIME_W + 1;
    localparam int IV_W       = 32;
    localparam int PER_W      = IV_W - 1;
    localparam int IDX_W      = 4;
    localparam int CNT_W      = $clog2(NUM_TIMERS + 1);
    localparam int REM_CNT_W  = $clog2(TIME_W + 1);

    localparam logic OP_ENABLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DIV
    } t_state;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [DL_W-1:0]  deadline;
        logic [PER_W-1:0] period;
        logic             one_shot;
    } t_entry;

    typedef struct packed {
        logic             shift;
        logic             put;
        logic [CNT_W-1:0] put_pos;
    } t_cell_ctl;

endpackage

/* rtl/core/tmb_in_if.sv */
// Command channel of the timer bank: enable and tick beats.
interface tmb_in_if;
    import tmb_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    opcode;
    logic [IDX_W-1:0]        timer_index;
    logic signed [IV_W-1:0]  interval;
    logic                    once_flag;
    logic [TIME_W-1:0]       now;

    modport source (output valid, opcode, timer_index, interval, once_flag, now,
                    input ready);
    modport sink   (input valid, opcode, timer_index, interval, once_flag, now,
                    output ready);
endinterface

/* rtl/core/tmb_out_if.sv */
// Fire channel of the timer bank: one beat per expired timer.
interface tmb_out_if;
    import tmb_pkg::*;

    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] fired_timer;
    logic             last;

    modport source (output valid, fired_timer, last, input ready);
    modport sink   (input valid, fired_timer, last, output ready);
endinterface

/* rtl/core/tmb_cell.sv */
// One slot of the enable-order chain: holds a timer entry, takes its neighbor's.
module tmb_cell import tmb_pkg::*; (
    input  logic             i_clk,
    input  t_cell_ctl        i_ctl,
    input  logic [CNT_W-1:0] i_pos,
    input  t_entry           i_next,
    input  t_entry           i_put,
    output t_entry           o_entry
);

    t_entry r_entry;
    t_entry n_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.put && (i_ctl.put_pos == i_pos)) begin
            n_entry = i_put;
        end else if (i_ctl.shift) begin
            n_entry = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

/* rtl/core/tmb_rem.sv */
// Bit-serial remainder unit: one restoring step per cycle.
module tmb_rem import tmb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [TIME_W-1:0] i_dividend,
    input  logic [PER_W-1:0]  i_divisor,
    output logic              o_done,
    output logic [PER_W-1:0]  o_rem
);

    logic                 r_busy;
    logic                 n_busy;
    logic [REM_CNT_W-1:0] r_cnt;
    logic [REM_CNT_W-1:0] n_cnt;
    logic [TIME_W-1:0]    r_shift;
    logic [TIME_W-1:0]    n_shift;
    logic [PER_W-1:0]     r_rem;
    logic [PER_W-1:0]     n_rem;
    logic [PER_W-1:0]     r_div;
    logic [PER_W-1:0]     n_div;
    logic [PER_W:0]       w_trial;
    logic [PER_W:0]       w_sub;

    assign w_trial = {r_rem, r_shift[TIME_W-1]};
    assign w_sub   = w_trial - {1'b0, r_div};
    assign o_done  = r_busy && (r_cnt == '0);
    assign o_rem   = r_rem;

    always_comb begin
        n_busy  = r_busy;
        n_cnt   = r_cnt;
        n_shift = r_shift;
        n_rem   = r_rem;
        n_div   = r_div;
        if (i_start) begin
            n_busy  = 1'b1;
            n_cnt   = REM_CNT_W'(TIME_W);
            n_shift = i_dividend;
            n_rem   = '0;
            n_div   = i_divisor;
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                n_busy = 1'b0;
            end else begin
                n_cnt   = r_cnt - 1'b1;
                n_shift = {r_shift[TIME_W-2:0], 1'b0};
                // subtract the divisor only when it fits into the trial value
                if (w_trial >= {1'b0, r_div}) begin
                    n_rem = w_sub[PER_W-1:0];
                end else begin
                    n_rem = w_trial[PER_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_shift <= n_shift;
        r_rem   <= n_rem;
        r_div   <= n_div;
    end

endmodule

/* rtl/core/periodic_oneshot_timer_bank.sv */
// Bank of periodic and one-shot timers, kept in enable order.
//
// i_in carries commands. An enable beat (opcode 0) disarms timer_index, then
// arms it: a positive interval at now + interval (periodic unless once_flag),
// a negative one as a one-shot at the absolute time -interval if that lies
// past now; zero leaves it disarmed. A tick beat (opcode 1) walks the armed
// timers in enable order and sends one o_out beat per timer whose deadline is
// at or before now; last marks the final beat of the tick. A fired one-shot
// is disarmed; a periodic timer moves on in whole periods past now.
// The armed timers sit in a chain of cells that rotates once per command,
// one timer per cycle through the head while no fire beat stalls and no
// remainder is in work. A periodic timer that has fallen at least one
// period behind waits at the head for a bit-serial remainder. The last fire
// beat shows on o_out in the cycle i_in.ready rises again. One command is in
// work at a time; i_in.ready is high only while idle. Fire beats leave
// through an output register; while o_out stalls, the walk holds at the
// next timer that fires. Reset disarms all timers and drops any pending beat.
module periodic_oneshot_timer_bank import tmb_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    tmb_in_if.sink   i_in,
    tmb_out_if.source o_out
);

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] r_left;
    logic [CNT_W-1:0] n_left;
    logic             r_op;
    logic             n_op;
    logic [TIME_W-1:0] r_now;
    logic [TIME_W-1:0] n_now;
    logic [IDX_W-1:0] r_tidx;
    logic [IDX_W-1:0] n_tidx;
    t_entry           r_new;
    t_entry           n_new;
    logic             r_arm;
    logic             n_arm;
    logic             r_pend_valid;
    logic             n_pend_valid;
    logic [IDX_W-1:0] r_pend_idx;
    logic [IDX_W-1:0] n_pend_idx;
    logic             r_out_valid;
    logic             n_out_valid;
    logic [IDX_W-1:0] r_out_idx;
    logic [IDX_W-1:0] n_out_idx;
    logic             r_out_last;
    logic             n_out_last;

    t_entry           w_cell [NUM_TIMERS];
    t_cell_ctl        w_ctl;
    t_entry           w_put;
    t_entry           w_head;

    logic             w_in_acc;
    logic [IV_W-1:0]  w_iv;
    logic [IV_W-1:0]  w_mag;
    logic             w_in_range;
    logic             w_due;
    logic [TIME_W-1:0] w_diff;
    logic             w_small;
    logic             w_drop_shot;
    logic             w_out_free;
    logic             w_hit;
    logic             w_tick_fire;
    logic             w_fire_block;
    logic             w_need_div;
    logic             w_flush_block;
    logic             w_rem_start;
    logic             w_rem_done;
    logic [PER_W-1:0] w_rem;
    logic [DL_W-1:0]  w_dl_step;
    logic [DL_W-1:0]  w_dl_div;

    // chain of cells, slot 0 is the head of the enable order
    for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
        t_entry w_next;
        if (g == NUM_TIMERS - 1) begin : g_tail
            assign w_next = w_cell[g];
        end else begin : g_body
            assign w_next = w_cell[g+1];
        end
        tmb_cell u_cell (
            .i_clk  (i_clk),
            .i_ctl  (w_ctl),
            .i_pos  (CNT_W'(g)),
            .i_next (w_next),
            .i_put  (w_put),
            .o_entry(w_cell[g])
        );
    end

    tmb_rem u_rem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_rem_start),
        .i_dividend(w_diff),
        .i_divisor (w_head.period),
        .o_done    (w_rem_done),
        .o_rem     (w_rem)
    );

    assign w_head        = w_cell[0];
    assign w_in_acc      = i_in.valid && i_in.ready;
    assign w_iv          = i_in.interval;
    assign w_mag         = ~w_iv + 1'b1;
    assign w_in_range    = int'(i_in.timer_index) < NUM_TIMERS;
    assign w_due         = w_head.deadline <= DL_W'(r_now);
    assign w_diff        = r_now - w_head.deadline[TIME_W-1:0];
    assign w_small       = w_diff < TIME_W'(w_head.period);
    assign w_drop_shot   = w_head.one_shot || (w_head.period == '0);
    assign w_out_free    = !r_out_valid || o_out.ready;
    assign w_hit         = w_head.idx == r_tidx;
    assign w_tick_fire   = (r_op == OP_TICK) && w_due;
    assign w_fire_block  = w_tick_fire && r_pend_valid && !w_out_free;
    assign w_need_div    = w_tick_fire && !w_drop_shot && !w_small;
    assign w_flush_block = (r_op == OP_TICK) && r_pend_valid && !w_out_free;
    // catch-up: now - ((now - deadline) mod period) + period
    assign w_dl_step     = w_head.deadline + DL_W'(w_head.period);
    assign w_dl_div      = DL_W'(r_now) - DL_W'(w_rem) + DL_W'(w_head.period);

    assign i_in.ready        = r_state == S_IDLE;
    assign o_out.valid       = r_out_valid;
    assign o_out.fired_timer = r_out_idx;
    assign o_out.last        = r_out_last;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_left != '0) begin
                    if (w_need_div && !w_fire_block) begin
                        n_state = S_DIV;
                    end
                end else if (!w_flush_block) begin
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                if (w_rem_done) begin
                    n_state = S_SCAN;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and chain control
    always_comb begin
        n_count      = r_count;
        n_left       = r_left;
        n_op         = r_op;
        n_now        = r_now;
        n_tidx       = r_tidx;
        n_new        = r_new;
        n_arm        = r_arm;
        n_pend_valid = r_pend_valid;
        n_pend_idx   = r_pend_idx;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_idx    = r_out_idx;
        n_out_last   = r_out_last;
        w_ctl.shift   = 1'b0;
        w_ctl.put     = 1'b0;
        w_ctl.put_pos = r_count - 1'b1;
        w_put         = w_head;
        w_rem_start   = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_op         = i_in.opcode;
                    n_now        = i_in.now;
                    n_tidx       = i_in.timer_index;
                    n_left       = r_count;
                    n_pend_valid = 1'b0;
                    n_new.idx    = i_in.timer_index;
                    if (w_iv[IV_W-1]) begin
                        n_new.deadline = DL_W'(w_mag);
                        n_new.period   = '0;
                        n_new.one_shot = 1'b1;
                        n_arm          = DL_W'(w_mag) > DL_W'(i_in.now);
                    end else begin
                        n_new.deadline = DL_W'(i_in.now) + DL_W'(w_iv);
                        n_new.period   = w_iv[PER_W-1:0];
                        n_new.one_shot = i_in.once_flag;
                        n_arm          = w_iv != '0;
                    end
                    if (!w_in_range) begin
                        n_arm = 1'b0;
                    end
                end
            end
            S_SCAN: begin
                if (r_left != '0) begin
                    if (r_op == OP_ENABLE) begin
                        // rotate, dropping the addressed timer
                        w_ctl.shift = 1'b1;
                        n_left      = r_left - 1'b1;
                        if (w_hit) begin
                            n_count = r_count - 1'b1;
                        end else begin
                            w_ctl.put = 1'b1;
                        end
                    end else if (!w_due) begin
                        w_ctl.shift = 1'b1;
                        w_ctl.put   = 1'b1;
                        n_left      = r_left - 1'b1;
                    end else if (!w_fire_block) begin
                        // hold each fire one step so the final one can carry last
                        if (r_pend_valid) begin
                            n_out_valid = 1'b1;
                            n_out_idx   = r_pend_idx;
                            n_out_last  = 1'b0;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_idx   = w_head.idx;
                        if (w_drop_shot) begin
                            w_ctl.shift = 1'b1;
                            n_count     = r_count - 1'b1;
                            n_left      = r_left - 1'b1;
                        end else if (w_small) begin
                            w_ctl.shift    = 1'b1;
                            w_ctl.put      = 1'b1;
                            w_put.deadline = w_dl_step;
                            n_left         = r_left - 1'b1;
                        end else begin
                            w_rem_start = 1'b1;
                        end
                    end
                end else if (r_op == OP_ENABLE) begin
                    if (r_arm) begin
                        w_ctl.put     = 1'b1;
                        w_ctl.put_pos = r_count;
                        w_put         = r_new;
                        n_count       = r_count + 1'b1;
                    end
                end else if (r_pend_valid && w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_idx    = r_pend_idx;
                    n_out_last   = 1'b1;
                    n_pend_valid = 1'b0;
                end
            end
            S_DIV: begin
                if (w_rem_done) begin
                    w_ctl.shift    = 1'b1;
                    w_ctl.put      = 1'b1;
                    w_put.deadline = w_dl_div;
                    n_left         = r_left - 1'b1;
                end
            end
            default: begin
                n_pend_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_left       <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_left       <= n_left;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
        r_op       <= n_op;
        r_now      <= n_now;
        r_tidx     <= n_tidx;
        r_new      <= n_new;
        r_arm      <= n_arm;
        r_pend_idx <= n_pend_idx;
        r_out_idx  <= n_out_idx;
        r_out_last <= n_out_last;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= CNT_W'(NUM_TIMERS)) && (r_left <= r_count))
        else $error("timer chain occupancy out of range");

    a_pend_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> (r_state != S_IDLE) && (r_op == OP_TICK))
        else $error("pending fire outside a tick walk");

    a_enable_no_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_op == OP_ENABLE && r_left != '0) |=>
        (r_count <= $past(r_count)))
        else $error("enable walk grew the chain");

    a_div_holds_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |=> (r_left == $past(r_left)) || $past(w_rem_done))
        else $error("chain moved during remainder step");

endmodule
